// ----- hw/rtl/eul_pkg.sv -----
// ----------------------------------------------------------------------------
// eul_pkg
// Shared constants, codes and control/status types of the Eulerian circuit
// finder.
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 2048;

    localparam int NW  = $clog2(MAX_NODES);          // node index
    localparam int EW  = $clog2(MAX_EDGES);          // edge index
    localparam int CW  = $clog2(MAX_EDGES + 2);      // counts, stack pointer
    localparam int AW  = $clog2(2 * MAX_EDGES);      // adjacency index
    localparam int OW  = $clog2(2 * MAX_EDGES + 1);  // adjacency offset
    localparam int DW  = 13;                         // degree, up to 2 * MAX_EDGES
    localparam int OFW = $clog2(MAX_NODES + 1);      // offset table index
    localparam int FW  = 11;                         // node fields

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IMPOSS  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic KIND_SOLVE  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR,
        S_CNT_E, S_CNT_RA, S_CNT_WA, S_CNT_RB, S_CNT_WB,
        S_PRE_R, S_PRE_W, S_PRE_END,
        S_FIL_E, S_FIL_RA, S_FIL_WA, S_FIL_RB, S_FIL_WB,
        S_CUR_R, S_CUR_W,
        S_WK_INIT, S_WK_TOP, S_WK_CMP, S_WK_EDGE, S_WK_USE, S_WK_POP,
        S_CHK_E, S_CHK_W,
        S_SOL_OUT, S_OVF_OUT, S_RD_R, S_RD_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CLR,
        OP_CNT_E, OP_CNT_RA, OP_CNT_WA, OP_CNT_RB, OP_CNT_WB,
        OP_PRE_R, OP_PRE_W, OP_PRE_END,
        OP_FIL_E, OP_FIL_RA, OP_FIL_WA, OP_FIL_RB, OP_FIL_WB,
        OP_CUR_R, OP_CUR_W,
        OP_WK_INIT, OP_WK_TOP, OP_WK_CMP, OP_WK_EDGE, OP_WK_USE, OP_WK_POP,
        OP_CHK_E, OP_CHK_W,
        OP_SOL_OUT, OP_OVF_OUT, OP_RD_R, OP_RD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
        logic idx_clr;
        logic idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_at_end;
        logic idx_clr_last;
        logic idx_node_last;
        logic sp_zero;
        logic cur_lt;
        logic ovf;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/eul_ctrl.sv -----
// ----------------------------------------------------------------------------
// eul_ctrl
// Sequencer: command decode, solve phases and Hierholzer walk steps.
// ----------------------------------------------------------------------------
module eul_ctrl import eul_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_command,
    input  t_dp_sts    i_sts,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_command)
                        CMD_SOLVE: n_state = i_sts.ovf ? S_OVF_OUT : S_CLR;
                        CMD_READ:  n_state = S_RD_R;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:     if (i_sts.idx_clr_last) n_state = S_CNT_E;
            S_CNT_E:   n_state = i_sts.idx_at_end ? S_PRE_R : S_CNT_RA;
            S_CNT_RA:  n_state = S_CNT_WA;
            S_CNT_WA:  n_state = S_CNT_RB;
            S_CNT_RB:  n_state = S_CNT_WB;
            S_CNT_WB:  n_state = S_CNT_E;
            S_PRE_R:   n_state = S_PRE_W;
            S_PRE_W:   n_state = i_sts.idx_node_last ? S_PRE_END : S_PRE_R;
            S_PRE_END: n_state = S_FIL_E;
            S_FIL_E:   n_state = i_sts.idx_at_end ? S_CUR_R : S_FIL_RA;
            S_FIL_RA:  n_state = S_FIL_WA;
            S_FIL_WA:  n_state = S_FIL_RB;
            S_FIL_RB:  n_state = S_FIL_WB;
            S_FIL_WB:  n_state = S_FIL_E;
            S_CUR_R:   n_state = S_CUR_W;
            S_CUR_W:   n_state = i_sts.idx_node_last ? S_WK_INIT : S_CUR_R;
            S_WK_INIT: n_state = S_WK_TOP;
            S_WK_TOP:  n_state = i_sts.sp_zero ? S_CHK_E : S_WK_CMP;
            S_WK_CMP:  n_state = i_sts.cur_lt ? S_WK_EDGE : S_WK_POP;
            S_WK_EDGE: n_state = S_WK_USE;
            S_WK_USE:  n_state = S_WK_TOP;
            S_WK_POP:  n_state = S_WK_TOP;
            S_CHK_E:   n_state = i_sts.idx_at_end ? S_SOL_OUT : S_CHK_W;
            S_CHK_W:   n_state = S_CHK_E;
            S_SOL_OUT: if (i_sts.out_free) n_state = S_IDLE;
            S_OVF_OUT: if (i_sts.out_free) n_state = S_IDLE;
            S_RD_R:    n_state = S_RD_OUT;
            S_RD_OUT:  if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_IDLE;
        o_stall       = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.accept  = i_valid;
                o_cmd.idx_clr = 1'b1;
            end
            S_CLR: begin
                o_cmd.op      = OP_CLR;
                o_cmd.idx_clr = i_sts.idx_clr_last;
                o_cmd.idx_inc = !i_sts.idx_clr_last;
            end
            S_CNT_E: begin
                o_cmd.op      = OP_CNT_E;
                o_cmd.idx_clr = i_sts.idx_at_end;
            end
            S_CNT_RA:  o_cmd.op = OP_CNT_RA;
            S_CNT_WA:  o_cmd.op = OP_CNT_WA;
            S_CNT_RB:  o_cmd.op = OP_CNT_RB;
            S_CNT_WB: begin
                o_cmd.op      = OP_CNT_WB;
                o_cmd.idx_inc = 1'b1;
            end
            S_PRE_R:   o_cmd.op = OP_PRE_R;
            S_PRE_W: begin
                o_cmd.op      = OP_PRE_W;
                o_cmd.idx_clr = i_sts.idx_node_last;
                o_cmd.idx_inc = !i_sts.idx_node_last;
            end
            S_PRE_END: o_cmd.op = OP_PRE_END;
            S_FIL_E: begin
                o_cmd.op      = OP_FIL_E;
                o_cmd.idx_clr = i_sts.idx_at_end;
            end
            S_FIL_RA:  o_cmd.op = OP_FIL_RA;
            S_FIL_WA:  o_cmd.op = OP_FIL_WA;
            S_FIL_RB:  o_cmd.op = OP_FIL_RB;
            S_FIL_WB: begin
                o_cmd.op      = OP_FIL_WB;
                o_cmd.idx_inc = 1'b1;
            end
            S_CUR_R:   o_cmd.op = OP_CUR_R;
            S_CUR_W: begin
                o_cmd.op      = OP_CUR_W;
                o_cmd.idx_inc = 1'b1;
            end
            S_WK_INIT: o_cmd.op = OP_WK_INIT;
            S_WK_TOP: begin
                o_cmd.op      = OP_WK_TOP;
                o_cmd.idx_clr = 1'b1;
            end
            S_WK_CMP:  o_cmd.op = OP_WK_CMP;
            S_WK_EDGE: o_cmd.op = OP_WK_EDGE;
            S_WK_USE:  o_cmd.op = OP_WK_USE;
            S_WK_POP:  o_cmd.op = OP_WK_POP;
            S_CHK_E:   o_cmd.op = OP_CHK_E;
            S_CHK_W: begin
                o_cmd.op      = OP_CHK_W;
                o_cmd.idx_inc = 1'b1;
            end
            S_SOL_OUT: o_cmd.op = OP_SOL_OUT;
            S_OVF_OUT: o_cmd.op = OP_OVF_OUT;
            S_RD_R:    o_cmd.op = OP_RD_R;
            S_RD_OUT:  o_cmd.op = OP_RD_OUT;
            default:   o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/eul_dp.sv -----
// ----------------------------------------------------------------------------
// eul_dp
// Datapath: edge, degree, offset, adjacency, cursor, used-mark, stack and
// circuit memories, counters and the result register.
// ----------------------------------------------------------------------------
module eul_dp import eul_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [1:0]    i_command,
    input  logic [FW-1:0] i_node_a,
    input  logic [FW-1:0] i_node_b,
    input  logic          i_cfg_we,
    input  logic [FW-1:0] i_cfg_data,
    input  logic          i_stall,
    output t_dp_sts       o_sts,
    output logic          o_valid,
    output logic          o_result_kind,
    output logic [1:0]    o_status,
    output logic [11:0]   o_circuit_length,
    output logic [FW-1:0] o_vertex,
    output logic          o_last
);

    logic [NW-1:0] r_ea   [MAX_EDGES];
    logic [NW-1:0] r_eb   [MAX_EDGES];
    logic [DW-1:0] r_deg  [MAX_NODES];
    logic [OW-1:0] r_off  [MAX_NODES + 1];
    logic [EW-1:0] r_adj  [2 * MAX_EDGES];
    logic [OW-1:0] r_cur  [MAX_NODES];
    logic          r_used [MAX_EDGES];
    logic [NW-1:0] r_stk  [MAX_EDGES + 1];
    logic [NW-1:0] r_cir  [MAX_EDGES + 1];

    logic [NW-1:0] r_ea_q, r_eb_q, r_stk_q, r_cir_q;
    logic [DW-1:0] r_deg_q;
    logic [OW-1:0] r_off_q, r_cur_q, r_sum;
    logic [EW-1:0] r_adj_q;
    logic          r_used_q;

    logic [FW-1:0] r_num_nodes;
    logic [CW-1:0] r_edge_cnt, r_cs, r_rp, r_sp, r_idx;
    logic          r_ovf, r_odd, r_bad;
    logic [NW-1:0] r_top;

    logic          r_ov, r_kind, r_last;
    logic [1:0]    r_stat;
    logic [11:0]   r_len;
    logic [FW-1:0] r_vtx;

    logic [FW-1:0] nlim;
    logic          a_ok, b_ok, add_ok, add_bad, is_add, is_clear;
    logic          out_free, out_set, pop, push, rd_ok;
    logic [NW-1:0] push_v;

    // memory ports
    logic          e_we, e_re, d_we, d_re, o_we, o_re, c_we, c_re;
    logic          a_we, a_re, u_we, u_re, s_we, s_re, r_we, r_re;
    logic [EW-1:0] e_ra, u_wa, u_ra;
    logic [NW-1:0] d_wa, d_ra, c_wa, c_ra;
    logic [DW-1:0] d_wd;
    logic [OFW-1:0] o_wa, o_ra;
    logic [OW-1:0] o_wd, c_wd;
    logic [AW-1:0] a_wa, a_ra;
    logic          u_wd;
    logic [CW-1:0] s_wa, s_ra, r_wa, r_ra;
    logic [NW-1:0] s_wd;

    assign nlim = (r_num_nodes == '0) ? FW'(1) :
                  (r_num_nodes > FW'(MAX_NODES)) ? FW'(MAX_NODES) : r_num_nodes;
    assign a_ok     = (i_node_a != '0) && (i_node_a <= nlim);
    assign b_ok     = (i_node_b != '0) && (i_node_b <= nlim);
    assign is_add   = i_cmd.accept && (i_command == CMD_ADD);
    assign is_clear = i_cmd.accept && (i_command == CMD_CLEAR);
    assign add_ok   = is_add && a_ok && b_ok && (r_edge_cnt < CW'(MAX_EDGES));
    assign add_bad  = is_add && !add_ok;
    assign out_free = !r_ov || !i_stall;
    assign out_set  = out_free && ((i_cmd.op == OP_SOL_OUT) || (i_cmd.op == OP_OVF_OUT) ||
                                   (i_cmd.op == OP_RD_OUT));
    assign pop      = (i_cmd.op == OP_WK_CMP) && !(r_cur_q < r_off_q);
    assign push     = (i_cmd.op == OP_WK_USE) && !r_used_q && (r_sp <= CW'(MAX_EDGES));
    assign push_v   = (r_ea_q == r_top) ? r_eb_q : r_ea_q;
    assign rd_ok    = r_rp < r_cs;

    assign o_sts.idx_at_end    = r_idx == r_edge_cnt;
    assign o_sts.idx_clr_last  = r_idx == CW'(MAX_EDGES - 1);
    assign o_sts.idx_node_last = r_idx == CW'(MAX_NODES - 1);
    assign o_sts.sp_zero       = r_sp == '0;
    assign o_sts.cur_lt        = r_cur_q < r_off_q;
    assign o_sts.ovf           = r_ovf;
    assign o_sts.out_free      = out_free;

    always_comb begin
        e_we = add_ok;
        e_re = 1'b0;
        e_ra = r_idx[EW-1:0];
        d_we = 1'b0; d_re = 1'b0;
        d_wa = r_idx[NW-1:0]; d_ra = r_idx[NW-1:0];
        d_wd = r_deg_q + DW'(1);
        o_we = 1'b0; o_re = 1'b0;
        o_wa = r_idx[OFW-1:0]; o_ra = r_idx[OFW-1:0];
        o_wd = r_sum;
        c_we = 1'b0; c_re = 1'b0;
        c_wa = r_idx[NW-1:0]; c_ra = r_top;
        c_wd = r_cur_q + OW'(1);
        a_we = 1'b0; a_re = 1'b0;
        a_wa = r_cur_q[AW-1:0]; a_ra = r_cur_q[AW-1:0];
        u_we = 1'b0; u_re = 1'b0;
        u_wa = r_idx[EW-1:0]; u_ra = r_adj_q; u_wd = 1'b0;
        s_we = 1'b0; s_re = 1'b0;
        s_wa = r_sp; s_ra = r_sp - CW'(2); s_wd = push_v;
        r_we = 1'b0; r_re = 1'b0;
        r_wa = r_cs; r_ra = r_cs - CW'(1) - r_rp;
        unique case (i_cmd.op)
            OP_CLR: begin
                d_we = r_idx < CW'(MAX_NODES);
                d_wd = '0;
                u_we = 1'b1;
            end
            OP_CNT_E, OP_FIL_E: e_re = !o_sts.idx_at_end;
            OP_CNT_RA: begin d_re = 1'b1; d_ra = r_ea_q; end
            OP_CNT_WA: begin d_we = 1'b1; d_wa = r_ea_q; end
            OP_CNT_RB: begin d_re = 1'b1; d_ra = r_eb_q; end
            OP_CNT_WB: begin d_we = 1'b1; d_wa = r_eb_q; end
            OP_PRE_R:  d_re = 1'b1;
            OP_PRE_W: begin
                o_we = 1'b1;
                c_we = 1'b1;
                c_wd = r_sum;
            end
            OP_PRE_END: begin
                o_we = 1'b1;
                o_wa = OFW'(MAX_NODES);
            end
            OP_FIL_RA: begin c_re = 1'b1; c_ra = r_ea_q; end
            OP_FIL_WA: begin a_we = 1'b1; c_we = 1'b1; c_wa = r_ea_q; end
            OP_FIL_RB: begin c_re = 1'b1; c_ra = r_eb_q; end
            OP_FIL_WB: begin a_we = 1'b1; c_we = 1'b1; c_wa = r_eb_q; end
            OP_CUR_R:  o_re = 1'b1;
            OP_CUR_W: begin
                c_we = 1'b1;
                c_wd = r_off_q;
            end
            OP_WK_INIT: begin
                s_we = 1'b1;
                s_wa = '0;
                s_wd = '0;
            end
            OP_WK_TOP: begin
                c_re = !o_sts.sp_zero;
                o_re = !o_sts.sp_zero;
                o_ra = OFW'(r_top) + OFW'(1);
            end
            OP_WK_CMP: begin
                if (!pop) begin
                    a_re = 1'b1;
                    c_we = 1'b1;
                    c_wa = r_top;
                end else begin
                    s_re = r_sp >= CW'(2);
                    r_we = r_cs <= CW'(MAX_EDGES);
                end
            end
            OP_WK_EDGE: begin
                e_re = 1'b1;
                e_ra = r_adj_q;
                u_re = 1'b1;
            end
            OP_WK_USE: begin
                u_we = push;
                u_wa = r_adj_q;
                u_wd = 1'b1;
                s_we = push;
            end
            OP_CHK_E: begin
                u_re = !o_sts.idx_at_end;
                u_ra = r_idx[EW-1:0];
            end
            OP_RD_R: r_re = rd_ok;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_ea[r_edge_cnt[EW-1:0]] <= NW'(i_node_a - FW'(1));
            r_eb[r_edge_cnt[EW-1:0]] <= NW'(i_node_b - FW'(1));
        end
        if (e_re) begin
            r_ea_q <= r_ea[e_ra];
            r_eb_q <= r_eb[e_ra];
        end
        if (d_we) r_deg[d_wa] <= d_wd;
        if (d_re) r_deg_q <= r_deg[d_ra];
        if (o_we) r_off[o_wa] <= o_wd;
        if (o_re) r_off_q <= r_off[o_ra];
        if (c_we) r_cur[c_wa] <= c_wd;
        if (c_re) r_cur_q <= r_cur[c_ra];
        if (a_we) r_adj[a_wa] <= r_idx[EW-1:0];
        if (a_re) r_adj_q <= r_adj[a_ra];
        if (u_we) r_used[u_wa] <= u_wd;
        if (u_re) r_used_q <= r_used[u_ra];
        if (s_we) r_stk[s_wa] <= s_wd;
        if (s_re) r_stk_q <= r_stk[s_ra];
        if (r_we) r_cir[r_wa] <= r_top;
        if (r_re) r_cir_q <= r_cir[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CLR: begin
                    r_sum <= '0;
                    r_odd <= 1'b0;
                    r_bad <= 1'b0;
                end
                OP_PRE_W: begin
                    r_sum <= r_sum + OW'(r_deg_q);
                    if (r_deg_q[0] && (r_idx < CW'(nlim))) r_odd <= 1'b1;
                end
                OP_WK_INIT: begin
                    r_sp  <= CW'(1);
                    r_top <= '0;
                end
                OP_WK_CMP: if (pop) r_sp <= r_sp - CW'(1);
                OP_WK_USE: begin
                    if (push) begin
                        r_sp  <= r_sp + CW'(1);
                        r_top <= push_v;
                    end
                end
                OP_WK_POP: r_top <= r_stk_q;
                OP_CHK_W:  if (!r_used_q) r_bad <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= FW'(1);
            r_edge_cnt  <= '0;
            r_cs        <= '0;
            r_rp        <= '0;
            r_ovf       <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) r_num_nodes <= i_cfg_data;
            if (add_ok) r_edge_cnt <= r_edge_cnt + CW'(1);
            if (add_bad) r_ovf <= 1'b1;
            if (is_clear) begin
                r_edge_cnt <= '0;
                r_cs       <= '0;
                r_rp       <= '0;
                r_ovf      <= 1'b0;
            end
            if (out_set) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_WK_INIT: begin
                    r_cs <= '0;
                    r_rp <= '0;
                end
                OP_WK_CMP: if (pop && (r_cs <= CW'(MAX_EDGES))) r_cs <= r_cs + CW'(1);
                OP_SOL_OUT: begin
                    if (out_free) begin
                        if (r_odd || r_bad) r_cs <= '0;
                    end
                end
                OP_OVF_OUT: begin
                    if (out_free) begin
                        r_cs <= '0;
                        r_rp <= '0;
                    end
                end
                OP_RD_OUT: begin
                    if (out_free) begin
                        if (rd_ok) r_rp <= r_rp + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            unique case (i_cmd.op)
                OP_SOL_OUT: begin
                    r_kind <= KIND_SOLVE;
                    r_stat <= (r_odd || r_bad) ? ST_IMPOSS : ST_OK;
                    r_len  <= (r_odd || r_bad) ? '0 : 12'(r_cs);
                    r_vtx  <= '0;
                    r_last <= 1'b0;
                end
                OP_OVF_OUT: begin
                    r_kind <= KIND_SOLVE;
                    r_stat <= ST_INVALID;
                    r_len  <= '0;
                    r_vtx  <= '0;
                    r_last <= 1'b0;
                end
                OP_RD_OUT: begin
                    r_kind <= KIND_VERTEX;
                    r_len  <= 12'(r_cs);
                    r_stat <= rd_ok ? ST_OK : ST_INVALID;
                    r_vtx  <= rd_ok ? (FW'(r_cir_q) + FW'(1)) : '0;
                    r_last <= rd_ok && ((r_rp + CW'(1)) == r_cs);
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_result_kind    = r_kind;
    assign o_status         = r_stat;
    assign o_circuit_length = r_len;
    assign o_vertex         = r_vtx;
    assign o_last           = r_last;

endmodule

// ----- hw/rtl/eulerian_circuit_finder_unit.sv -----
// ----------------------------------------------------------------------------
// eulerian_circuit_finder_unit
// Undirected Eulerian circuit finder (Hierholzer walk from node 1).
// ----------------------------------------------------------------------------
// Add and clear words may arrive back to back. A read goes through a circuit
// memory read, then the result register. Solve runs its phases through
// single-port memories: clear used marks and degrees, count degrees per
// edge, the prefix sum over the degrees, fill adjacency lists, reset
// cursors, the walk over the adjacency entries and pushed vertices, and
// the unused-edge check per edge. A solve with an earlier bad add returns
// its status without running these phases. Input is stalled while a solve
// or read is in progress.
module eulerian_circuit_finder_unit import eul_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_command,
    input  logic [FW-1:0] i_node_a,
    input  logic [FW-1:0] i_node_b,
    input  logic          i_cfg_we,
    input  logic [FW-1:0] i_cfg_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_result_kind,
    output logic [1:0]    o_status,
    output logic [11:0]   o_circuit_length,
    output logic [FW-1:0] o_vertex,
    output logic          o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    eul_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_sts     (sts),
        .o_stall   (o_stall),
        .o_cmd     (cmd)
    );

    eul_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_command        (i_command),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_stall          (i_stall),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_status         (o_status),
        .o_circuit_length (o_circuit_length),
        .o_vertex         (o_vertex),
        .o_last           (o_last)
    );

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Eulerian circuit finder unit. Edge, solve, read
// and clear words are driven with random sender gaps and receiver stalls. A
// behavioral Hierholzer walk kept in the bench predicts every status and
// vertex word, and a monitor checks each output word against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import eul_pkg::*; ();

    localparam int IDLE_LIMIT = 400000;

    typedef struct {
        logic        kind;
        logic [1:0]  st;
        logic [11:0] len;
        logic [10:0] vx;
        logic        lst;
    } t_circuit_word;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [1:0]    i_command = CMD_ADD;
    logic [FW-1:0] i_node_a = '0;
    logic [FW-1:0] i_node_b = '0;
    logic          i_cfg_we = 1'b0;
    logic [FW-1:0] i_cfg_data = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic          o_result_kind;
    logic [1:0]    o_status;
    logic [11:0]   o_circuit_length;
    logic [FW-1:0] o_vertex;
    logic          o_last;

    eulerian_circuit_finder_unit dut (.*);

    always #10 i_clk = ~i_clk;

    // graph shadow
    int unsigned nodes_cfg;
    int unsigned edge_cnt;
    int unsigned end_a [MAX_EDGES];
    int unsigned end_b [MAX_EDGES];
    int unsigned degree [MAX_NODES];
    int unsigned adj_off [MAX_NODES + 1];
    int unsigned adj_ent [2 * MAX_EDGES];
    int unsigned cursor [MAX_NODES];
    bit          used [MAX_EDGES];
    int unsigned walk [MAX_EDGES + 1];
    int unsigned circ [MAX_EDGES + 1];
    int unsigned circ_size;
    int unsigned read_ptr;
    bit          bad_add;

    t_circuit_word pending_words[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int solves = 0;
    int circuits_found = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    function automatic int unsigned node_cap();
        if (nodes_cfg < 1) return 1;
        if (nodes_cfg > MAX_NODES) return MAX_NODES;
        return nodes_cfg;
    endfunction

    function automatic void wipe_graph();
        edge_cnt = 0;
        foreach (degree[i]) degree[i] = 0;
        foreach (used[i]) used[i] = 1'b0;
        circ_size = 0;
        read_ptr = 0;
        bad_add = 1'b0;
    endfunction

    // Hierholzer walk from node 1; returns ST_OK or ST_IMPOSS
    function automatic logic [1:0] walk_circuit();
        int unsigned v, e, sp, sum;
        sum = 0;
        for (v = 0; v < MAX_NODES; v++) begin
            adj_off[v] = sum;
            cursor[v] = sum;
            sum += degree[v];
        end
        adj_off[MAX_NODES] = sum;
        for (e = 0; e < edge_cnt; e++) begin
            adj_ent[cursor[end_a[e]]] = e;
            cursor[end_a[e]]++;
            adj_ent[cursor[end_b[e]]] = e;
            cursor[end_b[e]]++;
        end
        for (v = 0; v < MAX_NODES; v++) cursor[v] = adj_off[v];
        foreach (used[i]) used[i] = 1'b0;
        circ_size = 0;
        read_ptr = 0;
        sp = 1;
        walk[0] = 0;
        while (sp > 0) begin
            v = walk[sp - 1];
            if (cursor[v] < adj_off[v + 1]) begin
                e = adj_ent[cursor[v]];
                cursor[v]++;
                if (!used[e] && sp <= MAX_EDGES) begin
                    used[e] = 1'b1;
                    walk[sp] = (end_a[e] == v) ? end_b[e] : end_a[e];
                    sp++;
                end
            end else begin
                sp--;
                if (circ_size <= MAX_EDGES) begin
                    circ[circ_size] = v;
                    circ_size++;
                end
            end
        end
        for (v = 0; v < node_cap(); v++)
            if (degree[v] & 1) begin
                circ_size = 0;
                return ST_IMPOSS;
            end
        for (e = 0; e < edge_cnt; e++)
            if (!used[e]) begin
                circ_size = 0;
                return ST_IMPOSS;
            end
        return ST_OK;
    endfunction

    function automatic void predict_word(logic [1:0] cmd, int unsigned a, int unsigned b);
        t_circuit_word w;
        int unsigned n;
        n = node_cap();
        case (cmd)
            CMD_ADD: begin
                if (a < 1 || a > n || b < 1 || b > n || edge_cnt >= MAX_EDGES) begin
                    bad_add = 1'b1;
                end else begin
                    end_a[edge_cnt] = a - 1;
                    end_b[edge_cnt] = b - 1;
                    degree[a - 1]++;
                    degree[b - 1]++;
                    edge_cnt++;
                end
            end
            CMD_CLEAR: wipe_graph();
            CMD_SOLVE: begin
                w.kind = KIND_SOLVE;
                if (bad_add) begin
                    circ_size = 0;
                    read_ptr = 0;
                    w.st = ST_INVALID;
                end else begin
                    w.st = walk_circuit();
                end
                w.len = (w.st == ST_OK) ? circ_size[11:0] : 12'd0;
                w.vx = '0;
                w.lst = 1'b0;
                solves++;
                if (w.st == ST_OK) circuits_found++;
                pending_words.push_back(w);
            end
            default: begin
                w.kind = KIND_VERTEX;
                w.len = circ_size[11:0];
                if (read_ptr < circ_size) begin
                    w.st = ST_OK;
                    w.vx = 11'(circ[circ_size - 1 - read_ptr] + 1);
                    w.lst = (read_ptr + 1 == circ_size);
                    read_ptr++;
                end else begin
                    w.st = ST_INVALID;
                    w.vx = '0;
                    w.lst = 1'b0;
                end
                pending_words.push_back(w);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_circuit_word w;
        if (i_rst_n && o_valid && !i_stall) begin
            words_out++;
            if (pending_words.size() == 0) begin
                report_mismatch("output word with nothing pending");
            end else begin
                w = pending_words.pop_front();
                if (o_result_kind !== w.kind)
                    report_mismatch($sformatf("kind %0b exp %0b", o_result_kind, w.kind));
                if (o_status !== w.st)
                    report_mismatch($sformatf("status %0d exp %0d", o_status, w.st));
                if (o_circuit_length !== w.len)
                    report_mismatch($sformatf("length %0d exp %0d", o_circuit_length, w.len));
                if (o_vertex !== w.vx)
                    report_mismatch($sformatf("vertex %0d exp %0d", o_vertex, w.vx));
                if (o_last !== w.lst)
                    report_mismatch($sformatf("last %0b exp %0b", o_last, w.lst));
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] cmd, int unsigned a = 0, int unsigned b = 0);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_node_a <= a[FW-1:0];
        i_node_b <= b[FW-1:0];
        do @(posedge i_clk); while (o_stall);
        words_in++;
        predict_word(cmd, a[FW-1:0], b[FW-1:0]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_nodes(int unsigned value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[FW-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        nodes_cfg = value & 32'h7FF;
    endtask

    task automatic read_all(int extra);
        int cnt;
        cnt = circ_size - read_ptr + extra;
        repeat (cnt) send_word(CMD_READ);
    endtask

    task automatic test_directed();
        send_word(CMD_READ);
        send_word(CMD_SOLVE);               // empty graph: single vertex 1
        read_all(1);
        write_nodes(0);                     // clamps to one node
        send_word(CMD_ADD, 1, 1);           // self-loop
        send_word(CMD_ADD, 2, 1);           // bad node
        send_word(CMD_SOLVE);
        send_word(CMD_READ);
        send_word(CMD_CLEAR);
        write_nodes(2047);                  // clamps to max
        send_word(CMD_ADD, 1, 1024);
        send_word(CMD_ADD, 1024, 1);
        send_word(CMD_ADD, 1, 1025);
        send_word(CMD_ADD, 2047, 0);
        send_word(CMD_SOLVE);
        send_word(CMD_CLEAR);
        send_word(CMD_ADD, 1, 1024);
        send_word(CMD_ADD, 1024, 1);
        send_word(CMD_ADD, 5, 6);           // odd nodes
        send_word(CMD_SOLVE);
        send_word(CMD_ADD, 6, 5);
        send_word(CMD_SOLVE);
        send_word(CMD_ADD, 7, 8);           // reads keep old circuit
        read_all(1);
        send_word(CMD_ADD, 8, 7);           // even but unreachable
        send_word(CMD_SOLVE);
        write_nodes(1);                     // lowered below nodes already in use
        send_word(CMD_ADD, 3, 3);
        send_word(CMD_CLEAR);
        write_nodes(1024);
        send_word(CMD_ADD, 1, 2);
        send_word(CMD_ADD, 2, 3);
        send_word(CMD_ADD, 3, 1);
        write_nodes(2);                     // lowered after adds
        send_word(CMD_SOLVE);
        send_word(CMD_SOLVE);
        read_all(2);
    endtask

    task automatic test_long_load();
        write_nodes(2);
        send_word(CMD_CLEAR);
        for (int i = 0; i < 120; i++)
            if ($urandom_range(0, 1)) send_word(CMD_ADD, 1, 2);
            else send_word(CMD_ADD, 2, 1);
        send_word(CMD_SOLVE);
        repeat (8) send_word(CMD_READ);
        send_word(CMD_ADD, 1, 3);           // bad node after a long load
        send_word(CMD_SOLVE);
        send_word(CMD_READ);
        send_word(CMD_CLEAR);
    endtask

    task automatic test_backpressure();
        write_nodes(4);
        send_word(CMD_ADD, 1, 2);
        send_word(CMD_ADD, 2, 3);
        send_word(CMD_ADD, 3, 4);
        send_word(CMD_ADD, 4, 1);
        send_word(CMD_SOLVE);
        hold_req = 1'b1;
        read_all(6);
        send_word(CMD_CLEAR);
    endtask

    task automatic test_random(int target);
        int unsigned n, cur, nxt, steps, kind;
        int start;
        start = words_in;
        while (words_in - start < target) begin
            n = $urandom_range(2, 8);
            if ($urandom_range(0, 3) == 0) write_nodes($urandom_range(0, 3) == 0 ?
                $urandom_range(0, 2047) : $urandom_range(n, 16));
            send_word(CMD_CLEAR);
            kind = $urandom_range(0, 9);
            cur = 1;
            steps = $urandom_range(1, 10);
            for (int i = 0; i < steps; i++) begin
                nxt = $urandom_range(1, n);
                send_word(CMD_ADD, cur, nxt);
                cur = nxt;
            end
            send_word(CMD_ADD, cur, 1);
            case (kind)
                6: send_word(CMD_ADD, $urandom_range(1, n), $urandom_range(1, n));
                7: repeat (2) send_word(CMD_ADD, n + 1, n + 2);
                8: send_word(CMD_ADD, $urandom_range(0, 2047), $urandom_range(0, 2047));
                9: repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), $urandom_range(0, 2047),
                              $urandom_range(0, 2047));
                default: ;
            endcase
            send_word(CMD_SOLVE);
            if ($urandom_range(0, 4) == 0) send_word(CMD_ADD, 1, 1);
            read_all($urandom_range(0, 2));
        end
    endtask

    initial begin
        nodes_cfg = 1;
        wipe_graph();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_long_load();
        test_random(380);
        quiet = 1'b1;
        test_random(80);
        drain();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d input words, %0d output words, %0d solves (%0d with a circuit),",
                 words_in, words_out, solves, circuits_found);
        $display("including long edge loads, bad nodes, clamped node counts and long stalls.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
